// ===== hdl/sliding_window_persistence_tracker_macros.svh =====
// assertion macros for the sliding window persistence tracker
// used by the top level only, no other dependencies
`ifndef SLIDING_WINDOW_PERSISTENCE_TRACKER_MACROS_SVH
`define SLIDING_WINDOW_PERSISTENCE_TRACKER_MACROS_SVH

// same-cycle implication
`define SWPT_ASSERT_IMPL(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWPT_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/swpt_pkg.sv =====
// shared constants and types of the sliding window persistence tracker
// no dependencies
`default_nettype none
package swpt_pkg;
  localparam int DEPTH      = 64;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = 7;
  localparam int SAMPLE_W   = 16;
  localparam int PERS_W     = 24;
  localparam int TALLY_W    = 32;
  localparam int MIN_WINDOW = 8;
  localparam int MIN_FLOOR  = 2;
  localparam logic [PERS_W-1:0] PERS_MAX = {PERS_W{1'b1}};

  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [1:0] REG_MIN_SAMPLES   = 2'd1;
  localparam logic [1:0] REG_THRESHOLD     = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t val;
    logic    vld;
  } stream_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pers;
    logic                hit;
  } res_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic latch;
    logic drain;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/swpt_cell.sv =====
// one window cell: holds a sample and scans both directions for its saddle merge
// depends on swpt_pkg
`default_nettype none
module swpt_cell (
  input  wire                        clk,
  input  swpt_pkg::cell_ctl_t        ctl,
  input  wire [swpt_pkg::IDX_W-1:0]  cell_idx,
  input  wire [swpt_pkg::CNT_W-1:0]  fill,
  input  wire [swpt_pkg::SAMPLE_W-1:0] thr,
  input  swpt_pkg::stream_t          nb_new_hold,
  input  swpt_pkg::stream_t          nb_old_hold,
  input  swpt_pkg::stream_t          nb_new_str,
  input  swpt_pkg::stream_t          nb_old_str,
  input  swpt_pkg::res_t             res_in,
  output swpt_pkg::stream_t          hold,
  output swpt_pkg::stream_t          new_str,
  output swpt_pkg::stream_t          old_str,
  output swpt_pkg::res_t             res_out
);
  import swpt_pkg::*;

  sample_t   v_r, lmin_r, rmin_r, mx;
  stream_t   o_r, e_r;
  logic      lopen_r, ropen_r, lnb_r, rnb_r, first_r;
  logic      vld, o_take, e_take;
  logic signed [SAMPLE_W:0] diff;
  res_t      res_r;

  assign vld     = {1'b0, cell_idx} < fill;
  assign hold    = '{val: v_r, vld: vld};
  assign new_str = e_r;
  assign old_str = o_r;
  assign res_out = res_r;

  // older side joins on ties, newer side only when strictly lower
  assign o_take = o_r.vld && (o_r.val <= v_r);
  assign e_take = e_r.vld && (e_r.val < v_r);
  assign mx     = (lmin_r > rmin_r) ? lmin_r : rmin_r;
  assign diff   = {v_r[SAMPLE_W-1], v_r} - {mx[SAMPLE_W-1], mx};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v_r <= nb_new_hold.val;
    end
    if (ctl.start) begin
      o_r     <= nb_old_hold;
      e_r     <= nb_new_hold;
      lopen_r <= 1'b1;
      ropen_r <= 1'b1;
      lmin_r  <= v_r;
      rmin_r  <= v_r;
      first_r <= 1'b1;
      lnb_r   <= 1'b0;
      rnb_r   <= 1'b0;
    end
    if (ctl.step) begin
      first_r <= 1'b0;
      if (first_r) begin
        lnb_r <= o_take;
        rnb_r <= e_take;
      end
      if (lopen_r) begin
        if (o_take) begin
          if (o_r.val < lmin_r) lmin_r <= o_r.val;
        end else begin
          lopen_r <= 1'b0;
        end
      end
      if (ropen_r) begin
        if (e_take) begin
          if (e_r.val < rmin_r) rmin_r <= e_r.val;
        end else begin
          ropen_r <= 1'b0;
        end
      end
      o_r <= nb_old_str;
      e_r <= nb_new_str;
    end
    if (ctl.latch) begin
      res_r.pers <= diff[SAMPLE_W-1:0];
      res_r.hit  <= vld && lnb_r && rnb_r && (diff[SAMPLE_W-1:0] > thr);
    end
    if (ctl.drain) begin
      res_r <= res_in;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sliding_window_persistence_tracker.sv =====
// Sliding window 0-dimensional sublevel persistence tracker. Each accepted sample
// (signed Q3.12) is shifted into a row of 64 cells, newest at cell 0. Once the fill
// reaches max(2, min_sample_count) every cell scans outward through two shifting
// streams to find whether it is a saddle (older neighbour not higher, newer lower)
// and the minima of the two basins it joins; the merge persistences are then shifted
// out of the row into a saturating accumulator. An item that triggers a computation
// goes through accept, start, scan steps, latch, drain and result, scan and drain
// set by the length of the cell row; otherwise accept, then result. One item is
// worked on at a time; the result register lets the next sample in while a result
// waits. Any configuration write to a valid register index restarts the tracker.
// depends on swpt_pkg, swpt_cell and sliding_window_persistence_tracker_macros.svh
`default_nettype none
`include "sliding_window_persistence_tracker_macros.svh"
module sliding_window_persistence_tracker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [15:0]  in_tdata,   // [15:0] sample_value
  output logic        out_tvalid,
  input  wire         out_tready,
  // [23:0] pers_total, [30:24] comp_count, [31] count_changed,
  // [38:32] previous_count, [70:39] change_events, [102:71] records_seen, [103] zero
  output logic [103:0] out_tdata,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire [1:0]   cfg_index,
  input  wire [15:0]  cfg_data
);
  import swpt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_START, S_SCAN, S_LATCH, S_DRAIN, S_DONE} state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    wlen_r, minc_r, fill_r, held_count_r, prior_r, merges_r;
  logic [SAMPLE_W-1:0] thr_r;
  logic                prior_vld_r;
  logic [PERS_W-1:0]   held_pers_r, acc_r;
  logic [TALLY_W-1:0]  events_r, records_r;
  logic [IDX_W-1:0]    cnt_r;

  logic [CNT_W-1:0]    w_eff, need, fill_nxt, merges_nxt;
  logic [PERS_W:0]     sum;
  logic [PERS_W-1:0]   acc_nxt;
  logic                in_xfer, cfg_xfer, restart, chg;
  cell_ctl_t           ctl;

  stream_t hold   [DEPTH];
  stream_t nstr   [DEPTH];
  stream_t ostr   [DEPTH];
  res_t    res    [DEPTH];

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign restart   = cfg_xfer && (cfg_index == REG_WINDOW_LENGTH ||
                     cfg_index == REG_MIN_SAMPLES || cfg_index == REG_THRESHOLD);

  // effective window and minimum sample count
  assign w_eff = (wlen_r < CNT_W'(MIN_WINDOW)) ? CNT_W'(MIN_WINDOW) :
                 (wlen_r > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : wlen_r;
  assign need  = (minc_r < CNT_W'(MIN_FLOOR)) ? CNT_W'(MIN_FLOOR) : minc_r;
  assign fill_nxt = (fill_r < w_eff) ? fill_r + 1'b1 : w_eff;

  // saturating accumulation of the merge persistence leaving cell 0
  assign sum        = {1'b0, acc_r} + {{(PERS_W+1-SAMPLE_W){1'b0}}, res[0].pers};
  assign acc_nxt    = !res[0].hit ? acc_r : (sum[PERS_W] ? PERS_MAX : sum[PERS_W-1:0]);
  assign merges_nxt = merges_r + CNT_W'(res[0].hit);

  assign chg = prior_vld_r && (held_count_r != prior_r);

  assign ctl = '{load: in_xfer, start: (state_r == S_START), step: (state_r == S_SCAN),
                 latch: (state_r == S_LATCH), drain: (state_r == S_DRAIN)};

  // row of cells; newer neighbour at lower index
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    stream_t nh, oh, ns, os;
    res_t    ri;
    if (k == 0) begin : g_first
      assign nh = '{val: sample_t'(in_tdata), vld: 1'b0};
      assign ns = '0;
    end else begin : g_mid
      assign nh = hold[k-1];
      assign ns = nstr[k-1];
    end
    if (k == DEPTH-1) begin : g_last
      assign oh = '0;
      assign os = '0;
      assign ri = '0;
    end else begin : g_body
      assign oh = hold[k+1];
      assign os = ostr[k+1];
      assign ri = res[k+1];
    end
    swpt_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .cell_idx    (IDX_W'(k)),
      .fill        (fill_r),
      .thr         (thr_r),
      .nb_new_hold (nh),
      .nb_old_hold (oh),
      .nb_new_str  (ns),
      .nb_old_str  (os),
      .res_in      (ri),
      .hold        (hold[k]),
      .new_str     (nstr[k]),
      .old_str     (ostr[k]),
      .res_out     (res[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wlen_r       <= CNT_W'(DEPTH);
      minc_r       <= CNT_W'(MIN_FLOOR);
      thr_r        <= '0;
      fill_r       <= '0;
      prior_vld_r  <= 1'b0;
      prior_r      <= '0;
      held_count_r <= '0;
      held_pers_r  <= '0;
      events_r     <= '0;
      records_r    <= '0;
      out_tvalid   <= 1'b0;
      cnt_r        <= '0;
      merges_r     <= '0;
      acc_r        <= '0;
    end else begin
      // a result loaded in S_DONE replaces the one leaving now
      if (out_tvalid && out_tready && state_r != S_DONE) out_tvalid <= 1'b0;
      if (restart) begin
        fill_r       <= '0;
        prior_vld_r  <= 1'b0;
        prior_r      <= '0;
        held_count_r <= '0;
        held_pers_r  <= '0;
        events_r     <= '0;
        records_r    <= '0;
        unique case (cfg_index)
          REG_WINDOW_LENGTH: wlen_r <= cfg_data[CNT_W-1:0];
          REG_MIN_SAMPLES:   minc_r <= cfg_data[CNT_W-1:0];
          REG_THRESHOLD:     thr_r  <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            records_r <= records_r + 1'b1;
            fill_r    <= fill_nxt;
            state_r   <= (fill_nxt >= need) ? S_START : S_DONE;
          end
        end
        S_START: begin
          cnt_r   <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          // distances 1 .. DEPTH-1
          if (cnt_r == IDX_W'(DEPTH-2)) state_r <= S_LATCH;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_LATCH: begin
          cnt_r    <= '0;
          acc_r    <= '0;
          merges_r <= '0;
          state_r  <= S_DRAIN;
        end
        S_DRAIN: begin
          acc_r    <= acc_nxt;
          merges_r <= merges_nxt;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == IDX_W'(DEPTH-1)) begin
            held_pers_r  <= acc_nxt;
            held_count_r <= merges_nxt + 1'b1;
            state_r      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid  <= 1'b1;
            out_tdata   <= {1'b0, records_r, events_r + TALLY_W'(chg),
                            chg ? prior_r : {CNT_W{1'b0}}, chg, held_count_r,
                            held_pers_r};
            events_r    <= events_r + TALLY_W'(chg);
            prior_r     <= held_count_r;
            prior_vld_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SWPT_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, held_count_r <= CNT_W'(DEPTH), "held count above window depth")
  `SWPT_ASSERT_NEXT(a_accept_fill, clk, rst_n, in_tvalid && in_tready && !restart, fill_r != '0, "fill not advanced after a transfer")
  `SWPT_ASSERT_IMPL(a_change_prev, clk, rst_n, out_tvalid && out_tdata[31], out_tdata[38:32] != out_tdata[30:24], "change flagged with equal counts")
endmodule
`default_nettype wire
